// ----- rtl/pls_pkg.sv -----
// Shared types and codes for the positional list store.
`default_nettype none

package pls_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int POS_W  = 5;
   localparam int LEN_W  = 5;
   localparam int STAT_W = 2;

   localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] item;
      logic [LEN_W-1:0]         length;
      logic                     last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/positional_list_store.sv -----
// Positional list store: ordered list of signed values with positional insert and delete.
//
// Usage: the req channel takes one command per item (insert head, insert tail,
// insert at 1-based position, delete at position, dump). Unused command codes
// are dropped with no result. req_stall is high while a command is in work;
// one command is handled at a time.
// Each insert or delete gives one status item on rsp. Dump gives one item per
// stored value, head first, last set on the final one, or a single empty
// status item when the list holds nothing.
// Timing: entries are moved one per cycle through the RAM's separate read and
// write ports. After accept, an insert or delete moves any entries after its
// index in ST_SHIFT, then goes to ST_RESP, which loads the status item into the
// output register; a rejected command goes from accept straight to ST_RESP.
// Dump reads its first value from the RAM, then loads one value per cycle while
// rsp does not stall.
// A stalled rsp holds its item; the sequencer waits on the output register
// while the next request stays blocked. Reset empties the list at once and
// drops any item in flight; RAM contents need no clearing.
`default_nettype none

module positional_list_store #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pls_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pls_pkg::rsp_type  rsp_data
);
   import pls_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SHIFT = 2'd1;
   localparam logic [1:0] ST_RESP  = 2'd2;
   localparam logic [1:0] ST_DUMP  = 2'd3;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              ins_ff, ins_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  waddr_ff, waddr_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   logic              out_free, load, consume, full;
   rsp_type           load_data;
   logic [CMP_W-1:0]  pos_x, cnt_x;
   logic [CNT_W-1:0]  ptr_dec, ptr_inc;

   pls_ram #(
      .DEPTH (CAPACITY),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (count_ff >= CAP_CNT);
   assign pos_x     = CMP_W'(req_data.position);
   assign cnt_x     = CMP_W'(count_ff);
   assign ptr_dec   = ptr_ff - 1'b1;
   assign ptr_inc   = ptr_ff + 1'b1;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      idx_in    = idx_ff;
      ins_in    = ins_ff;
      pend_in   = pend_ff;
      waddr_in  = waddr_ff;
      val_in    = val_ff;
      stat_in   = stat_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = val_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      load      = 1'b0;
      consume   = 1'b0;
      load_data = '0;

      case (state_ff)
         ST_IDLE: begin
            pend_in = 1'b0;
            if (req_valid) begin
               val_in = req_data.value;
               case (req_data.command)
                  CMD_INS_HEAD, CMD_INS_TAIL: begin
                     if (full) begin
                        stat_in  = STAT_FULL;
                        state_in = ST_RESP;
                     end else begin
                        ins_in   = 1'b1;
                        ptr_in   = count_ff;
                        idx_in   = (req_data.command == CMD_INS_HEAD) ? '0 : count_ff;
                        state_in = ST_SHIFT;
                     end
                  end
                  CMD_INS_POS: begin
                     if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                        stat_in  = STAT_BADPOS;
                        state_in = ST_RESP;
                     end else if (full) begin
                        stat_in  = STAT_FULL;
                        state_in = ST_RESP;
                     end else begin
                        ins_in   = 1'b1;
                        ptr_in   = count_ff;
                        idx_in   = CNT_W'(pos_x - 1'b1);
                        state_in = ST_SHIFT;
                     end
                  end
                  CMD_DEL_POS: begin
                     if (pos_x == '0 || pos_x > cnt_x) begin
                        stat_in  = STAT_BADPOS;
                        state_in = ST_RESP;
                     end else begin
                        ins_in   = 1'b0;
                        ptr_in   = CNT_W'(pos_x - 1'b1);
                        state_in = ST_SHIFT;
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        stat_in  = STAT_EMPTY;
                        state_in = ST_RESP;
                     end else begin
                        ptr_in   = '0;
                        state_in = ST_DUMP;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = waddr_ff;
               wr_data = rd_data;
            end
            if (ins_ff) begin
               if (ptr_ff > idx_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = ptr_dec[IDX_W-1:0];
                  waddr_in = ptr_ff[IDX_W-1:0];
                  ptr_in   = ptr_dec;
                  pend_in  = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     wr_en    = 1'b1;
                     wr_addr  = idx_ff[IDX_W-1:0];
                     wr_data  = val_ff;
                     count_in = count_ff + 1'b1;
                     stat_in  = STAT_OK;
                     state_in = ST_RESP;
                  end
               end
            end else begin
               if (ptr_inc < count_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = ptr_inc[IDX_W-1:0];
                  waddr_in = ptr_ff[IDX_W-1:0];
                  ptr_in   = ptr_inc;
                  pend_in  = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     count_in = count_ff - 1'b1;
                     stat_in  = STAT_OK;
                     state_in = ST_RESP;
                  end
               end
            end
         end

         ST_RESP: begin
            if (out_free) begin
               load             = 1'b1;
               load_data.status = stat_ff;
               load_data.item   = '0;
               load_data.length = cnt_x[LEN_W-1:0];
               load_data.last   = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         ST_DUMP: begin
            consume = pend_ff && out_free;
            if (consume) begin
               load             = 1'b1;
               load_data.status = STAT_OK;
               load_data.item   = rd_data;
               load_data.length = cnt_x[LEN_W-1:0];
               load_data.last   = (ptr_ff == count_ff);
            end
            if (ptr_ff < count_ff && (!pend_ff || out_free)) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_inc;
               pend_in = 1'b1;
            end else if (consume) begin
               pend_in = 1'b0;
            end
            if (consume && ptr_ff == count_ff) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_in       = load_data;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      idx_ff   <= idx_in;
      ins_ff   <= ins_in;
      waddr_ff <= waddr_in;
      val_ff   <= val_in;
      stat_ff  <= stat_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // fill level bound
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("count above capacity");

   // fill level moves by one item at most
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |->
         (count_ff == CNT_W'($past(count_ff) + 1'b1) ||
          count_ff == CNT_W'($past(count_ff) - 1'b1)))
      else $error("count jumped");

   // only a dump leaves a non-final item waiting
   a_nonlast_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> (state_ff == ST_DUMP))
      else $error("non-final item outside dump");

   // no RAM traffic while idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!wr_en && !rd_en))
      else $error("RAM access while idle");

endmodule

`default_nettype wire

// ----- rtl/pls_ram.sv -----
// Entry storage: one write port, one read port with registered read data.
`default_nettype none

module pls_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [pls_pkg::DATA_W-1:0]   wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [pls_pkg::DATA_W-1:0]   rd_data
);
   import pls_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- verif/positional_list_store_test.sv -----
// Self-checking testbench for the positional list store: directed table, then random command mixes.
module positional_list_store_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pls_pkg::*;

   localparam int CAPACITY      = 16;
   localparam int NUM_ROWS      = 20;
   localparam int NUM_PHASES    = 12;
   localparam int PHASE_ITEMS   = 36;
   localparam int LONG_HOLD     = 200;
   localparam int SETTLE_CYCLES = 40;

   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_MIXED} mix_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] value;
      logic [4:0]        reps;
      logic              rnd_value;
      logic              has_exp;
      logic [STAT_W-1:0] exp_status;
      logic [LEN_W-1:0]  exp_length;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   logic signed [DATA_W-1:0] list_shadow [$];
   rsp_type                  awaited_results [$];
   int                       mismatches     = 0;
   int                       gap_pct        = 25;
   bit                       quiet          = 1'b0;
   bit                       want_long_hold = 1'b0;

   plan_row_type plan [NUM_ROWS] = '{
      '{CMD_DUMP,        5'd0,  32'h0000_0000, 5'd1,  1'b0, 1'b1, STAT_EMPTY,  5'd0},
      '{CMD_DEL_POS,     5'd1,  32'h0000_0000, 5'd1,  1'b0, 1'b1, STAT_BADPOS, 5'd0},
      '{CMD_INS_POS,     5'd0,  32'h0000_0001, 5'd1,  1'b0, 1'b1, STAT_BADPOS, 5'd0},
      '{CMD_INS_POS,     5'd2,  32'h0000_0001, 5'd1,  1'b0, 1'b1, STAT_BADPOS, 5'd0},
      '{CMD_INS_POS,     5'd1,  32'h7FFF_FFFF, 5'd1,  1'b0, 1'b1, STAT_OK,     5'd1},
      '{CMD_INS_HEAD,    5'd31, 32'h8000_0000, 5'd1,  1'b0, 1'b1, STAT_OK,     5'd2},
      '{CMD_INS_TAIL,    5'd0,  32'hFFFF_FFFF, 5'd1,  1'b0, 1'b1, STAT_OK,     5'd3},
      '{CMD_INS_POS,     5'd2,  32'h0000_0000, 5'd1,  1'b0, 1'b1, STAT_OK,     5'd4},
      '{CMD_SPARE_FIRST, 5'd31, 32'hFFFF_FFFF, 5'd1,  1'b0, 1'b0, STAT_OK,     5'd0},
      '{CMD_SPARE_LAST,  5'd0,  32'h0000_0000, 5'd1,  1'b0, 1'b0, STAT_OK,     5'd0},
      '{CMD_DUMP,        5'd0,  32'h0000_0000, 5'd1,  1'b0, 1'b0, STAT_OK,     5'd0},
      '{CMD_DEL_POS,     5'd5,  32'h0000_0000, 5'd1,  1'b0, 1'b1, STAT_BADPOS, 5'd4},
      '{CMD_DEL_POS,     5'd4,  32'h0000_0000, 5'd1,  1'b0, 1'b1, STAT_OK,     5'd3},
      '{CMD_INS_TAIL,    5'd0,  32'h0000_0000, 5'd13, 1'b1, 1'b0, STAT_OK,     5'd0},
      '{CMD_INS_HEAD,    5'd0,  32'h1234_5678, 5'd1,  1'b0, 1'b1, STAT_FULL,   5'd16},
      '{CMD_INS_POS,     5'd18, 32'h1234_5678, 5'd1,  1'b0, 1'b1, STAT_BADPOS, 5'd16},
      '{CMD_INS_POS,     5'd17, 32'h1234_5678, 5'd1,  1'b0, 1'b1, STAT_FULL,   5'd16},
      '{CMD_DUMP,        5'd0,  32'h0000_0000, 5'd1,  1'b0, 1'b0, STAT_OK,     5'd0},
      '{CMD_DEL_POS,     5'd16, 32'h0000_0000, 5'd1,  1'b0, 1'b1, STAT_OK,     5'd15},
      '{CMD_DEL_POS,     5'd1,  32'h0000_0000, 5'd1,  1'b0, 1'b1, STAT_OK,     5'd14}
   };

   positional_list_store #(.CAPACITY(CAPACITY)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Updates the shadow list and, when record is set, queues the results the command gives.
   function automatic void apply_to_list(input req_type r, input bit record);
      rsp_type res;
      int      n;
      bit      one_status;
      n = list_shadow.size();
      res = '0;
      res.last = 1'b1;
      one_status = 1'b1;
      case (r.command)
         CMD_INS_HEAD, CMD_INS_TAIL: begin
            if (n >= CAPACITY) res.status = STAT_FULL;
            else if (r.command == CMD_INS_HEAD) list_shadow.push_front(r.value);
            else list_shadow.push_back(r.value);
         end
         CMD_INS_POS: begin
            if (r.position < 1 || r.position > n + 1) res.status = STAT_BADPOS;
            else if (n >= CAPACITY) res.status = STAT_FULL;
            else list_shadow.insert(r.position - 1, r.value);
         end
         CMD_DEL_POS: begin
            if (r.position < 1 || r.position > n) res.status = STAT_BADPOS;
            else list_shadow.delete(r.position - 1);
         end
         CMD_DUMP: begin
            if (n == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               one_status = 1'b0;
               for (int i = 0; i < n; i++) begin
                  res.item   = list_shadow[i];
                  res.length = LEN_W'(n);
                  res.last   = (i == n - 1);
                  if (record) awaited_results.push_back(res);
               end
            end
         end
         default: one_status = 1'b0;
      endcase
      res.length = LEN_W'(list_shadow.size());
      if (one_status && record) awaited_results.push_back(res);
   endfunction

   // Mostly well-formed positions for the current fill level, some noise.
   function automatic req_type pick_command(input mix_type mode);
      req_type r;
      int      n;
      int      roll;
      int      ins_pct;
      int      del_pct;
      n = list_shadow.size();
      case (mode)
         MIX_FILL:  begin ins_pct = 60; del_pct = 15; end
         MIX_DRAIN: begin ins_pct = 20; del_pct = 60; end
         default:   begin ins_pct = 35; del_pct = 35; end
      endcase
      r.position = POS_W'($urandom);
      case ($urandom_range(0, 9))
         0:       r.value = 32'h8000_0000;
         1:       r.value = 32'h7FFF_FFFF;
         default: r.value = $urandom;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
         case ($urandom_range(0, 2))
            0:       r.command = CMD_INS_HEAD;
            1:       r.command = CMD_INS_TAIL;
            default: begin
               r.command  = CMD_INS_POS;
               r.position = POS_W'($urandom_range(1, n + 1));
            end
         endcase
      end else if (roll < ins_pct + del_pct) begin
         r.command = CMD_DEL_POS;
         if (n > 0) r.position = POS_W'($urandom_range(1, n));
      end else if (roll < 90) begin
         r.command = CMD_DUMP;
      end else if (roll < 95) begin
         r.command = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end else begin
         r.command = ($urandom_range(0, 1) == 0) ? CMD_INS_POS : CMD_DEL_POS;
      end
      return r;
   endfunction

   task automatic send_command(input req_type r, input bit has_exp,
                               input logic [STAT_W-1:0] exp_status,
                               input logic [LEN_W-1:0] exp_length);
      rsp_type fixed_rsp;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (has_exp) begin
         fixed_rsp        = '0;
         fixed_rsp.status = exp_status;
         fixed_rsp.length = exp_length;
         fixed_rsp.last   = 1'b1;
         awaited_results.push_back(fixed_rsp);
      end
      apply_to_list(r, !has_exp);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   initial begin : cmd_side
      req_type r;
      int      counted;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         for (int k = 0; k < plan[i].reps; k++) begin
            r.command  = plan[i].command;
            r.position = plan[i].position;
            r.value    = plan[i].rnd_value ? $urandom : plan[i].value;
            send_command(r, plan[i].has_exp, plan[i].exp_status, plan[i].exp_length);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         quiet   = (ph >= NUM_PHASES - 2);
         gap_pct = 25 * $urandom_range(0, 2);
         if (ph == 1) want_long_hold = 1'b1;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            r = pick_command(mix_type'(ph % 3));
            if (r.command <= CMD_DUMP) counted++;
            send_command(r, 1'b0, STAT_OK, '0);
         end
      end
      req_valid <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("** positional_list_store: PASSED **");
      end else begin
         $display("** positional_list_store: FAILED **");
      end
      $finish;
   end

   initial begin : rsp_side
      bit held;
      held      = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (want_long_hold && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < 20) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual %p", $time, rsp_data);
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("item",   32'(want.item),   32'(rsp_data.item));
            check_field("length", 32'(want.length), 32'(rsp_data.length));
            check_field("last",   32'(want.last),   32'(rsp_data.last));
         end
      end
   end

   initial begin : watchdog
      #3ms;
      $display("** positional_list_store: FAILED **");
      $finish;
   end

endmodule
